[rtl/atfc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atfc_pkg
// shared types and constants of the box transform and frustum cull pipeline
// ----------------------------------------------------------------------------
package atfc_pkg;

    localparam int NUM_PLANES = 6;
    localparam int CFG_PLANES = 6;
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int HALF_BITS  = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 64;
    localparam int PROD_BITS  = 2 * HALF_BITS;
    localparam int SUM_BITS   = PROD_BITS + 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_CULL_ENABLE = 3'd0;

    // one plane-test stage carries the world box and the running verdict
    typedef struct packed {
        logic                        valid;
        logic                        has_bounds;
        logic                        visible;
        logic [3*HALF_BITS-1:0]      wmin;
        logic [3*HALF_BITS-1:0]      wmax;
    } t_beat;

    function automatic logic signed [HALF_BITS-1:0] half16(
        input logic [4*HALF_BITS-1:0] w, input int idx);
        half16 = w[idx*HALF_BITS +: HALF_BITS];
    endfunction

endpackage

[rtl/atfc_xform.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atfc_xform
// transforms the box into world space: interval products per matrix entry,
// then floor, saturate and pack of the enclosing world box
// ----------------------------------------------------------------------------
module atfc_xform (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic                     i_has_bounds,
    input  logic [47:0]              i_local_min,
    input  logic [47:0]              i_local_max,
    input  logic [63:0]              i_row_x,
    input  logic [63:0]              i_row_y,
    input  logic [63:0]              i_row_z,
    output atfc_pkg::t_beat          o_beat
);
    localparam int PB = atfc_pkg::PROD_BITS;
    localparam int SB = atfc_pkg::SUM_BITS;

    // stage 1: per row and column, min and max of m*lo and m*hi
    logic signed [PB-1:0] r_pmin [3][3];
    logic signed [PB-1:0] r_pmax [3][3];
    logic signed [15:0]   r_tr   [3];
    logic                 r_v1, r_hb1;

    logic [63:0] rows [3];
    assign rows[0] = i_row_x;
    assign rows[1] = i_row_y;
    assign rows[2] = i_row_z;

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                logic signed [PB-1:0] a, b;
                a = atfc_pkg::half16(rows[r], k) * atfc_pkg::half16({16'd0, i_local_min}, k);
                b = atfc_pkg::half16(rows[r], k) * atfc_pkg::half16({16'd0, i_local_max}, k);
                r_pmin[r][k] <= (a < b) ? a : b;
                r_pmax[r][k] <= (a < b) ? b : a;
            end
            r_tr[r] <= atfc_pkg::half16(rows[r], 3);
        end
        r_hb1 <= i_has_bounds;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
    end

    // stage 2: sums, floor shift, saturate (monotonic, so min/max carry through)
    function automatic logic [15:0] fsat(input logic signed [SB-1:0] s);
        logic signed [SB-1:0] f;
        f = s >>> atfc_pkg::FRAC_BITS;
        if (f > SB'(2 ** (atfc_pkg::COORD_BITS - 1) - 1))
            fsat = 16'(2 ** (atfc_pkg::COORD_BITS - 1) - 1);
        else if (f < -SB'(2 ** (atfc_pkg::COORD_BITS - 1)))
            fsat = 16'(-(2 ** (atfc_pkg::COORD_BITS - 1)));
        else
            fsat = f[15:0];
    endfunction

    atfc_pkg::t_beat n_beat;
    always_comb begin
        n_beat = '0;
        n_beat.valid      = r_v1;
        n_beat.has_bounds = r_hb1;
        n_beat.visible    = 1'b1;
        for (int r = 0; r < 3; r++) begin
            logic signed [SB-1:0] t, smin, smax;
            t = SB'(r_tr[r]) <<< atfc_pkg::FRAC_BITS;
            smin = SB'(r_pmin[r][0]) + SB'(r_pmin[r][1]) + SB'(r_pmin[r][2]) + t;
            smax = SB'(r_pmax[r][0]) + SB'(r_pmax[r][1]) + SB'(r_pmax[r][2]) + t;
            n_beat.wmin[r*16 +: 16] = r_hb1 ? fsat(smin) : 16'd0;
            n_beat.wmax[r*16 +: 16] = r_hb1 ? fsat(smax) : 16'd0;
        end
    end

    atfc_pkg::t_beat r_beat;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= '0;
        end else begin
            r_beat <= n_beat;
        end
    end
    assign o_beat = r_beat;

endmodule

[rtl/atfc_plane_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atfc_plane_cell
// one plane of the chain: holds its coefficients, tests the nearest corner
// and hands the beat on, products registered before the sum
// ----------------------------------------------------------------------------
module atfc_plane_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cull_en,
    input  logic                 i_plane_we,
    input  logic [63:0]          i_plane_data,
    input  atfc_pkg::t_beat      i_beat,
    output atfc_pkg::t_beat      o_beat
);
    localparam int PB = atfc_pkg::PROD_BITS;
    localparam int SB = atfc_pkg::SUM_BITS;

    logic [63:0]          r_plane;
    logic signed [PB-1:0] r_prod [3];
    atfc_pkg::t_beat      r_mid, r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (i_plane_we) begin
            r_plane <= i_plane_data;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            logic signed [15:0] a;
            a = atfc_pkg::half16(r_plane, k);
            r_prod[k] <= a * ((a > 0) ? $signed(i_beat.wmin[k*16 +: 16])
                                      : $signed(i_beat.wmax[k*16 +: 16]));
        end
    end

    logic signed [SB-1:0] sum;
    atfc_pkg::t_beat      n_out;
    always_comb begin
        sum = (SB'(atfc_pkg::half16(r_plane, 3)) <<< atfc_pkg::FRAC_BITS)
            + SB'(r_prod[0]) + SB'(r_prod[1]) + SB'(r_prod[2]);
        n_out = r_mid;
        if (i_cull_en && r_mid.has_bounds && sum > 0) begin
            n_out.visible = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid <= '0;
            r_out <= '0;
        end else begin
            r_mid <= i_beat;
            r_out <= n_out;
        end
    end
    assign o_beat = r_out;

endmodule

[rtl/aabb_transform_frustum_cull.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_transform_frustum_cull
// world-space box transform followed by a chain of plane-test cells
// ----------------------------------------------------------------------------
// One box is taken every cycle (busy stays low); its result strobes on
// o_done after two transform stages plus two stages in each of the six
// plane cells. The receiver cannot stall, so every result must be taken
// in its strobe cycle. Configuration may be written only when no box is in
// flight.
module aabb_transform_frustum_cull (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_has_bounds,
    input  logic [47:0] i_local_min,
    input  logic [47:0] i_local_max,
    input  logic [63:0] i_row_x,
    input  logic [63:0] i_row_y,
    input  logic [63:0] i_row_z,
    output logic        o_done,
    output logic        o_visible,
    output logic        o_bounds_valid,
    output logic [47:0] o_world_min,
    output logic [47:0] o_world_max
);
    localparam int NP = atfc_pkg::NUM_PLANES;

    logic r_cull_en;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cull_en <= 1'b0;
        end else if (i_cfg_we && i_cfg_idx == atfc_pkg::REG_CULL_ENABLE) begin
            r_cull_en <= i_cfg_data[0];
        end
    end

    assign busy = 1'b0;

    atfc_pkg::t_beat chain [NP+1];

    atfc_xform u_xform (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (start),
        .i_has_bounds (i_has_bounds),
        .i_local_min  (i_local_min),
        .i_local_max  (i_local_max),
        .i_row_x      (i_row_x),
        .i_row_y      (i_row_y),
        .i_row_z      (i_row_z),
        .o_beat       (chain[0])
    );

    for (genvar g = 0; g < NP; g++) begin : g_cell
        logic we;
        assign we = i_cfg_we && (g < atfc_pkg::CFG_PLANES)
                 && (32'(i_cfg_idx) == 32'(g + 1));
        atfc_plane_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cull_en    (r_cull_en),
            .i_plane_we   (we),
            .i_plane_data (i_cfg_data),
            .i_beat       (chain[g]),
            .o_beat       (chain[g+1])
        );
    end

    assign o_done         = chain[NP].valid;
    assign o_visible      = chain[NP].visible;
    assign o_bounds_valid = chain[NP].has_bounds;
    assign o_world_min    = chain[NP].wmin;
    assign o_world_max    = chain[NP].wmax;

endmodule
